/* rtl/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, constants and the duty pattern ROM for the haptic sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int ROM_ROWS    = 4;
  localparam int ROM_COLS    = 31;
  localparam int STEP_W      = 5;
  localparam int SEL_W       = 2;
  localparam int DUTY_W      = 8;
  localparam int CNT_W       = 8;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CFG  = 1'b1;

  localparam logic [DUTY_W-1:0] DUTY_ROM [ROM_ROWS][ROM_COLS] = '{
    '{8'd64, 8'd127, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127, 8'd64, 8'd0,
      8'd0, 8'd64, 8'd127, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127, 8'd64,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd64, 8'd127, 8'd255, 8'd255, 8'd127, 8'd64, 8'd0, 8'd0, 8'd64, 8'd127,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127, 8'd64,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd35, 8'd50, 8'd65, 8'd80, 8'd95, 8'd110, 8'd125, 8'd140, 8'd155, 8'd170,
      8'd185, 8'd200, 8'd215, 8'd230, 8'd245, 8'd255, 8'd255, 8'd255, 8'd127, 8'd64,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  // classified request as it travels from front to back
  typedef struct packed {
    logic             is_cfg;
    logic [SEL_W-1:0] sel;
    logic             cnt_zero;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_next;
  } hps_op_t;

  function automatic logic [DUTY_W-1:0] rom_read(input logic [SEL_W-1:0]  pat,
                                                 input logic [STEP_W-1:0] step);
    logic [DUTY_W-1:0] val;
    if (step >= STEP_W'(ROM_COLS)) begin
      val = '0;
    end else begin
      val = DUTY_ROM[pat][step];
    end
    return val;
  endfunction

endpackage

/* rtl/hps_if.sv */
// ----------------------------------------------------------------------------
// hps_if
// Request and result channels of the haptic sequencer.
// ----------------------------------------------------------------------------
interface hps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [hps_pkg::SEL_W-1:0]   pattern_sel;
  logic [hps_pkg::CNT_W-1:0]   repeat_count;

  modport source (output valid, req_type, pattern_sel, repeat_count, input ready);
  modport sink   (input valid, req_type, pattern_sel, repeat_count, output ready);
endinterface

interface hps_out_if;
  logic                        valid;
  logic                        ready;
  logic [hps_pkg::DUTY_W-1:0]  duty;
  logic                        motor_enabled;
  logic                        busy_res;

  modport source (output valid, duty, motor_enabled, busy_res, input ready);
  modport sink   (input valid, duty, motor_enabled, busy_res, output ready);
endinterface

/* rtl/hps_front.sv */
// ----------------------------------------------------------------------------
// hps_front
// Accepts requests, clamps the selector and precomputes the repeat values.
// ----------------------------------------------------------------------------
module hps_front #(
  parameter int PATTERN_COUNT = 3
) (
  hps_in_if.sink             in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output hps_pkg::hps_op_t   push_op
);

  localparam logic [hps_pkg::SEL_W:0]   PCNT    = (hps_pkg::SEL_W+1)'(PATTERN_COUNT);
  localparam logic [hps_pkg::SEL_W-1:0] SEL_MAX = hps_pkg::SEL_W'(PATTERN_COUNT - 1);
  localparam logic [hps_pkg::CNT_W-1:0] CNT_MAX = '1;

  always_comb begin
    push_op.is_cfg   = (in_ch.req_type == hps_pkg::REQ_CFG);
    push_op.sel      = ({1'b0, in_ch.pattern_sel} >= PCNT) ? SEL_MAX : in_ch.pattern_sel;
    push_op.cnt      = in_ch.repeat_count;
    push_op.cnt_zero = (in_ch.repeat_count == '0);
    // count plus one, saturating
    push_op.cnt_next = (in_ch.repeat_count == CNT_MAX) ? CNT_MAX
                                                       : in_ch.repeat_count + 1'b1;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

/* rtl/hps_queue.sv */
// ----------------------------------------------------------------------------
// hps_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module hps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hps_pkg::hps_op_t   push_op,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hps_pkg::hps_op_t   pop_op
);

  hps_pkg::hps_op_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* rtl/hps_back.sv */
// ----------------------------------------------------------------------------
// hps_back
// Executes ticks and configure requests and holds the result register.
// ----------------------------------------------------------------------------
module hps_back #(
  parameter int STEPS_PER_PATTERN = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  hps_pkg::hps_op_t   pop_op,
  hps_out_if.source          out_ch
);

  localparam logic [hps_pkg::STEP_W-1:0] STEP_LIMIT = hps_pkg::STEP_W'(STEPS_PER_PATTERN);

  logic [hps_pkg::SEL_W-1:0]  active_r, active_nxt;
  logic [hps_pkg::SEL_W-1:0]  queued_r, queued_nxt;
  logic [hps_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [hps_pkg::CNT_W-1:0]  repeats_r, repeats_nxt;
  logic [hps_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic                       on_r, on_nxt;
  logic                       busy_r, busy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       pop;
  logic                       running;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;
  assign running   = (repeats_r != '0);

  always_comb begin
    active_nxt  = active_r;
    queued_nxt  = queued_r;
    step_nxt    = step_r;
    repeats_nxt = repeats_r;
    duty_nxt    = duty_r;
    on_nxt      = on_r;
    busy_nxt    = busy_r;
    if (pop) begin
      if (pop_op.is_cfg) begin
        queued_nxt = pop_op.sel;
        if (!running && !pop_op.cnt_zero) begin
          busy_nxt    = 1'b1;
          active_nxt  = pop_op.sel;
          repeats_nxt = pop_op.cnt;
          on_nxt      = 1'b1;
        end else if (running && pop_op.cnt_zero) begin
          repeats_nxt = hps_pkg::CNT_W'(1);
        end else if (running) begin
          repeats_nxt = pop_op.cnt_next;
        end
      end else if (running) begin
        if (step_r >= STEP_LIMIT) begin
          // end of pass
          repeats_nxt = repeats_r - 1'b1;
          if (repeats_r == hps_pkg::CNT_W'(1)) begin
            duty_nxt = '0;
            on_nxt   = 1'b0;
            busy_nxt = 1'b0;
          end
          step_nxt   = '0;
          active_nxt = queued_r;
        end else begin
          on_nxt   = 1'b1;
          duty_nxt = hps_pkg::rom_read(active_r, step_r);
          step_nxt = step_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      queued_r    <= '0;
      step_r      <= '0;
      repeats_r   <= hps_pkg::CNT_W'(1);
      duty_r      <= '0;
      on_r        <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      queued_r    <= queued_nxt;
      step_r      <= step_nxt;
      repeats_r   <= repeats_nxt;
      duty_r      <= duty_nxt;
      on_r        <= on_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty          = duty_r;
  assign out_ch.motor_enabled = on_r;
  assign out_ch.busy_res      = busy_r;

`ifndef SYNTH
  a_busy_has_motor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> on_r)
    else $error("busy without motor enabled");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !running |-> (duty_r == '0) && !on_r && !busy_r)
    else $error("idle with motor state left over");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LIMIT)
    else $error("step position past pattern end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(duty_r) && $stable(repeats_r))
    else $error("state changed while result stalled");
`endif

endmodule

/* rtl/haptic_pattern_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer_unit
// Vibration pattern sequencer: plays duty steps from a pattern ROM per tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   req_type, pattern_sel, repeat_count
//  out_ch   out  valid/ready   duty, motor_enabled, busy_res
//
//  One request per cycle sustained while out_ch.ready stays high; a request is
//  registered in the queue and then in the back end before it shows on out_ch.
//  The back end updates state once per popped request; the two-entry
//  queue absorbs short output stalls before in_ch.ready drops.
//  Reset (rst_n low, synchronous) arms one wakeup pass with busy clear.
//  A stalled result holds all state until out_ch.ready is seen.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer_unit #(
  parameter int STEPS_PER_PATTERN = 20,
  parameter int PATTERN_COUNT     = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  hps_in_if.sink     in_ch,
  hps_out_if.source  out_ch
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  hps_pkg::hps_op_t push_op, pop_op;

  hps_front #(
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  hps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  hps_back #(
    .STEPS_PER_PATTERN (STEPS_PER_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_ch    (out_ch)
  );

endmodule
